// ===== design/jrt_pkg.sv =====
`default_nettype none

package jrt_pkg;

    localparam int DEFAULT_ENTRIES = 256;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_number;
        logic [31:0] sequence_req;
    } in_item_t;

    typedef struct packed {
        logic revoked;
        logic already_present;
        logic dropped;
    } out_item_t;

    typedef struct packed {
        logic [63:0] block;
        logic [31:0] seq;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/jrt_table.sv =====
`default_nettype none

module jrt_table #(
    parameter int ENTRIES = jrt_pkg::DEFAULT_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire jrt_pkg::entry_t  wr_entry,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_idx,
    output jrt_pkg::entry_t       rd_entry
);

    jrt_pkg::entry_t mem [ENTRIES];
    jrt_pkg::entry_t rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= mem[rd_idx];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

// ===== design/journal_revoke_table_unit.sv =====
// Each item is compared against the filled entries in turn, one entry read and compared per
// cycle over the single table read port; the walk ends early when the block matches. A new
// item is accepted only after the result of the one before is placed in the output register,
// which waits while an earlier result has not been taken.
// Reset: aresetn (synchronous, active low) empties the table and clears the
// handshakes; entry contents are not cleared.
`default_nettype none

module journal_revoke_table_unit #(
    parameter int ENTRIES = jrt_pkg::DEFAULT_ENTRIES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire jrt_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output jrt_pkg::out_item_t     m_item
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    jrt_pkg::state_t    state_reg, state_next;
    jrt_pkg::in_item_t  item_reg, item_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [31:0]        old_seq_reg, old_seq_next;
    logic               m_valid_reg, m_valid_next;
    jrt_pkg::out_item_t m_item_reg, m_item_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    jrt_pkg::entry_t    wr_entry;
    logic               rd_en;
    jrt_pkg::entry_t    rd_entry;
    logic               out_free;

    jrt_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_idx   (rd_ptr_reg[IDX_W-1:0]),
        .rd_entry (rd_entry)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == jrt_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= jrt_pkg::ST_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        cmp_idx_reg <= cmp_idx_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        old_seq_reg <= old_seq_next;
        m_item_reg  <= m_item_next;
    end

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        old_seq_next   = old_seq_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_item_next    = m_item_reg;
        wr_en          = 1'b0;
        wr_idx         = slot_reg;
        wr_entry       = '{block: item_reg.block_number, seq: item_reg.sequence_req};
        rd_en          = 1'b0;

        unique case (state_reg)
            jrt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next   = s_item;
                    rd_ptr_next = '0;
                    found_next  = 1'b0;
                    state_next  = jrt_pkg::ST_SCAN;
                end
            end
            jrt_pkg::ST_SCAN: begin
                if (cmp_valid_reg && rd_entry.block == item_reg.block_number) begin
                    found_next   = 1'b1;
                    slot_next    = cmp_idx_reg;
                    old_seq_next = rd_entry.seq;
                    state_next   = jrt_pkg::ST_DONE;
                end else if (rd_ptr_reg < count_reg) begin
                    rd_en          = 1'b1;
                    rd_ptr_next    = rd_ptr_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_ptr_reg[IDX_W-1:0];
                end else if (!cmp_valid_reg) begin
                    state_next = jrt_pkg::ST_DONE;
                end
            end
            jrt_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_item_next.already_present = found_reg;
                    m_item_next.revoked         = (item_reg.cmd == jrt_pkg::CMD_CHECK)
                                                  && found_reg
                                                  && (old_seq_reg >= item_reg.sequence_req);
                    m_item_next.dropped         = 1'b0;
                    if (item_reg.cmd == jrt_pkg::CMD_ADD) begin
                        if (found_reg) begin
                            wr_en = item_reg.sequence_req > old_seq_reg;
                        end else if (count_reg < FULL_CNT) begin
                            wr_en      = 1'b1;
                            wr_idx     = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end else begin
                            m_item_next.dropped = 1'b1;
                        end
                    end
                    state_next = jrt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jrt_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count beyond capacity");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= $past(count_reg))
        else $error("entry count decreased");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_ptr_reg <= count_reg)
        else $error("scan pointer past filled entries");

    a_revoked_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_item_reg.revoked || m_item_reg.already_present))
        else $error("revoked without a matching entry");

    a_dropped_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.dropped |-> !m_item_reg.already_present
            && count_reg == FULL_CNT)
        else $error("drop without a full table or of a present block");

endmodule

`default_nettype wire
